>>> rtl/boid_flock_update_defines.svh
// ----------------------------------------------------------------------------
// boid_flock_update_defines
// Assertion macros shared by the boid flocking block.
// ----------------------------------------------------------------------------
`ifndef BOID_FLOCK_UPDATE_DEFINES_SVH
`define BOID_FLOCK_UPDATE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define BFU_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("boid_flock_update: check failed");

// next-cycle implication
`define BFU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("boid_flock_update: check failed");

`endif

>>> rtl/bfu_pkg.sv
// ----------------------------------------------------------------------------
// bfu_pkg
// Types, widths and helpers for the boid flocking block.
// ----------------------------------------------------------------------------
package bfu_pkg;

    localparam int VW  = 24;   // position / velocity, Q7.16
    localparam int XW  = 25;   // difference vector
    localparam int UW  = 18;   // unit vector component, Q.16
    localparam int MW  = 26;   // multiplier operand
    localparam int PW  = 52;   // product
    localparam int AW2 = 50;   // sum of squares
    localparam int RW  = 48;   // root radicand
    localparam int RTW = 24;   // root
    localparam int QW  = 41;   // divider numerator / quotient
    localparam int DW  = 25;   // divider denominator
    localparam int SPW = 31;   // position sum
    localparam int SUW = 24;   // unit vector sum
    localparam int CW  = 7;    // neighbor count

    localparam logic [6:0]  RST_COUNT  = 7'd30;
    localparam logic [15:0] RST_SEP    = 16'd30802;
    localparam logic [15:0] RST_COH    = 16'd29491;
    localparam logic [15:0] RST_ALN    = 16'd19661;
    localparam logic [15:0] RST_TGT    = 16'd655;
    localparam logic [22:0] RST_RADIUS = 23'd163840;
    localparam logic [22:0] RST_MAXSPD = 23'd196608;
    localparam logic [22:0] RST_BOUND  = 23'd655360;

    typedef enum logic [2:0] {
        REG_COUNT,
        REG_SEP,
        REG_COH,
        REG_ALN,
        REG_TGT,
        REG_RADIUS,
        REG_MAXSPD,
        REG_BOUND
    } cfg_reg_t;

    typedef enum logic {
        OP_LOAD,
        OP_STEP
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LD_WR,
        ST_LD_WB,
        ST_R2,
        ST_MS2,
        ST_MS2W,
        ST_BRD,
        ST_BRD2,
        ST_NRD,
        ST_NQ,
        ST_NCMP,
        ST_NACC,
        ST_NNEXT,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_TGT,
        ST_VINIT,
        ST_VM,
        ST_VA,
        ST_SPD,
        ST_SCMP,
        ST_CAPI,
        ST_CAPM,
        ST_CAPA,
        ST_WRAP,
        ST_WB,
        ST_EMIT,
        ST_SQ,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT
    } state_t;

    localparam logic signed [37:0] SAT_MAX = 38'sd8388607;
    localparam logic signed [37:0] SAT_MIN = -38'sd8388608;

    function automatic logic signed [VW-1:0] sat24(input logic signed [37:0] x);
        logic signed [VW-1:0] r;
        if (x > SAT_MAX)
        begin
            r = 24'sh7FFFFF;
        end
        else if (x < SAT_MIN)
        begin
            r = 24'sh800000;
        end
        else
        begin
            r = x[VW-1:0];
        end
        return r;
    endfunction

    // Q.16 product scaled back, truncated toward zero
    function automatic logic signed [35:0] mulq(input logic signed [PW-1:0] pr);
        logic signed [PW-1:0] adj;
        adj = pr + (pr[PW-1] ? 52'sd65535 : 52'sd0);
        return adj[PW-1:16];
    endfunction

endpackage

>>> rtl/bfu_div.sv
// ----------------------------------------------------------------------------
// bfu_div
// Restoring divider, signed numerator by unsigned denominator, one quotient
// bit per cycle, result truncated toward zero.
// ----------------------------------------------------------------------------
module bfu_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [bfu_pkg::QW-1:0] num,
    input  logic        [bfu_pkg::DW-1:0] den,
    output logic                          done,
    output logic signed [bfu_pkg::QW-1:0] quot
);
    import bfu_pkg::*;

    logic          busy_reg;
    logic          done_reg;
    logic [5:0]    cnt_reg;
    logic          neg_reg;
    logic [QW-2:0] mag_reg;
    logic [DW:0]   rem_reg;
    logic [DW-1:0] den_reg;
    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_next;
    logic          qbit;
    logic [QW-1:0] abs_num;

    always_comb
    begin
        rem_sh   = {rem_reg[DW-1:0], mag_reg[QW-2]};
        qbit     = rem_sh >= {1'b0, den_reg};
        rem_next = qbit ? rem_sh - {1'b0, den_reg} : rem_sh;
        abs_num  = num[QW-1] ? -num : num;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(QW - 2))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[QW-1];
            mag_reg <= abs_num[QW-2:0];
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            mag_reg <= {mag_reg[QW-3:0], qbit};
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});

endmodule

>>> rtl/bfu_sqrt.sv
// ----------------------------------------------------------------------------
// bfu_sqrt
// Integer square root (floor), two radicand bits per cycle.
// ----------------------------------------------------------------------------
module bfu_sqrt (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [bfu_pkg::RW-1:0]   rad,
    output logic                     done,
    output logic [bfu_pkg::RTW-1:0]  root
);
    import bfu_pkg::*;

    logic           busy_reg;
    logic           done_reg;
    logic [4:0]     cnt_reg;
    logic [RW-1:0]  rad_reg;
    logic [RTW-1:0] root_reg;
    logic [RTW+2:0] rem_reg;
    logic [RTW+2:0] rem_sh;
    logic [RTW+2:0] trial;
    logic           take;

    always_comb
    begin
        rem_sh = {rem_reg[RTW:0], rad_reg[RW-1:RW-2]};
        trial  = {1'b0, root_reg, 2'b01};
        take   = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(RTW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= take ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[RTW-2:0], take};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> rtl/boid_flock_update.sv
// ----------------------------------------------------------------------------
// boid_flock_update
// Fixed-point boids flocking step over a position and a velocity memory.
// ----------------------------------------------------------------------------
// A load beat (tuser 0) with an index below MAX_BOIDS stores one boid and
// sets its velocity to three times its unit position; it returns nothing.
// A step beat (tuser 1) updates boids 0..n-1 in place and returns one beat
// per boid, tlast on the final one. Each boid scans all n boids through the
// single memory read port, with one square root and three divides for the
// unit velocity of each neighbor inside the radius, then works out the
// averages, the pull toward the origin, the update, the speed cap and the
// wrap of x and y at the bound. Input is taken only while the block is
// idle, so neither a load nor a step in progress overlaps the next beat.
`include "boid_flock_update_defines.svh"

module boid_flock_update #(
    parameter int MAX_BOIDS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    // config write
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [22:0]  cfg_data,
    // input beats
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // boid_index[5:0], load_x[29:6], load_y[53:30], load_z[77:54],
    // time_step[93:78], zero pad
    input  logic [95:0]  s_axis_tdata,
    // operation[0]
    input  logic [0:0]   s_axis_tuser,
    // result beats
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_index[5:0], new_x[29:6], new_y[53:30], new_z[77:54],
    // speed_x[101:78], speed_y[125:102], speed_z[149:126], zero pad
    output logic [151:0] m_axis_tdata,
    output logic         m_axis_tlast
);
    import bfu_pkg::*;

    localparam int AW = $clog2(MAX_BOIDS);

    // configuration
    logic [6:0]  count_reg;
    logic [15:0] sep_reg, coh_reg, aln_reg, tgt_reg;
    logic [22:0] radius_reg, maxspd_reg, bound_reg;

    // control
    state_t       state_reg, state_next;
    state_t       sq_ret_reg, sq_ret_next;
    state_t       u_ret_reg, u_ret_next;
    logic [2:0]   k_reg, k_next;
    logic [2:0]   term_reg, term_next;
    logic [AW-1:0] i_reg, i_next, j_reg, j_next;
    logic [AW:0]  n_reg, n_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // datapath
    logic [15:0]             dt_reg, dt_next;
    logic signed [VW-1:0]    p_reg [3], p_next [3];
    logic signed [VW-1:0]    v_reg [3], v_next [3];
    logic signed [VW-1:0]    avg_reg [3], avg_next [3];
    logic signed [UW-1:0]    ali_reg [3], ali_next [3];
    logic signed [UW-1:0]    u_reg [3], u_next [3];
    logic signed [XW-1:0]    vec_reg [3], vec_next [3];
    logic signed [SPW-1:0]   sum_p_reg [3], sum_p_next [3];
    logic signed [SUW-1:0]   sum_u_reg [3], sum_u_next [3];
    logic [AW2-1:0]          acc_reg, acc_next;
    logic [45:0]             r2_reg, r2_next, ms2_reg, ms2_next;
    logic [RTW-1:0]          len_reg, len_next;
    logic signed [PW-1:0]    prod_reg;
    logic signed [MW-1:0]    mul_a, mul_b;

    // memories
    logic [3*VW-1:0] pos_mem [MAX_BOIDS];
    logic [3*VW-1:0] vel_mem [MAX_BOIDS];
    logic [3*VW-1:0] pos_rd_reg, vel_rd_reg;
    logic [AW-1:0]   rd_addr;
    logic            mem_we;

    // shared units
    logic                  sqrt_start, sqrt_done;
    logic [RTW-1:0]        sqrt_root;
    logic                  div_start, div_done;
    logic signed [QW-1:0]  div_num, div_quot;
    logic [DW-1:0]         div_den;

    bfu_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .rad   (acc_reg[RW-1:0]),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    bfu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // input fields
    logic [5:0]          in_idx;
    logic signed [VW-1:0] in_pos [3];
    logic [15:0]         in_dt;

    always_comb
    begin
        in_idx    = s_axis_tdata[5:0];
        in_pos[0] = s_axis_tdata[29:6];
        in_pos[1] = s_axis_tdata[53:30];
        in_pos[2] = s_axis_tdata[77:54];
        in_dt     = s_axis_tdata[93:78];
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= RST_COUNT;
            sep_reg    <= RST_SEP;
            coh_reg    <= RST_COH;
            aln_reg    <= RST_ALN;
            tgt_reg    <= RST_TGT;
            radius_reg <= RST_RADIUS;
            maxspd_reg <= RST_MAXSPD;
            bound_reg  <= RST_BOUND;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_COUNT:  count_reg  <= cfg_data[6:0];
                REG_SEP:    sep_reg    <= cfg_data[15:0];
                REG_COH:    coh_reg    <= cfg_data[15:0];
                REG_ALN:    aln_reg    <= cfg_data[15:0];
                REG_TGT:    tgt_reg    <= cfg_data[15:0];
                REG_RADIUS: radius_reg <= cfg_data;
                REG_MAXSPD: maxspd_reg <= cfg_data;
                REG_BOUND:  bound_reg  <= cfg_data;
                default:    count_reg  <= count_reg;
            endcase
        end
    end

    // memories: one write port at i_reg, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pos_mem[i_reg] <= {p_reg[2], p_reg[1], p_reg[0]};
            vel_mem[i_reg] <= {v_reg[2], v_reg[1], v_reg[0]};
        end
        pos_rd_reg <= pos_mem[rd_addr];
        vel_rd_reg <= vel_mem[rd_addr];
    end

    always_comb
    begin
        logic [1:0]           kx;
        logic [2:0]           km3;
        logic signed [35:0]   mq;
        logic signed [XW-1:0] bnd, nbnd, pw;
        logic signed [19:0]   t3;

        state_next  = state_reg;
        sq_ret_next = sq_ret_reg;
        u_ret_next  = u_ret_reg;
        k_next      = k_reg;
        term_next   = term_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        n_next      = n_reg;
        cnt_next    = cnt_reg;
        dt_next     = dt_reg;
        p_next      = p_reg;
        v_next      = v_reg;
        avg_next    = avg_reg;
        ali_next    = ali_reg;
        u_next      = u_reg;
        vec_next    = vec_reg;
        sum_p_next  = sum_p_reg;
        sum_u_next  = sum_u_reg;
        acc_next    = acc_reg;
        r2_next     = r2_reg;
        ms2_next    = ms2_reg;
        len_next    = len_reg;
        mul_a       = '0;
        mul_b       = '0;
        sqrt_start  = 1'b0;
        div_start   = 1'b0;
        div_num     = '0;
        div_den     = '0;
        mem_we      = 1'b0;
        rd_addr     = j_reg;
        kx          = k_reg[1:0];
        km3         = k_reg - 3'd3;
        mq          = mulq(prod_reg);
        bnd         = $signed({2'b00, bound_reg});
        nbnd        = -bnd;
        pw          = '0;
        t3          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (op_t'(s_axis_tuser[0]) == OP_LOAD)
                    begin
                        if ({1'b0, in_idx} < 7'(MAX_BOIDS))
                        begin
                            i_next = in_idx[AW-1:0];
                            for (int kk = 0; kk < 3; kk++)
                            begin
                                p_next[kk]   = in_pos[kk];
                                vec_next[kk] = XW'(in_pos[kk]);
                            end
                            k_next      = '0;
                            sq_ret_next = ST_SQRT_GO;
                            u_ret_next  = ST_LD_WR;
                            state_next  = ST_SQ;
                        end
                    end
                    else if (count_reg != 7'd0)
                    begin
                        n_next = (count_reg > 7'(MAX_BOIDS)) ? (AW+1)'(MAX_BOIDS)
                                                             : (AW+1)'(count_reg);
                        dt_next    = in_dt;
                        i_next     = '0;
                        cnt_next   = '0;
                        state_next = ST_R2;
                    end
                end
            end
            ST_LD_WR:
            begin
                for (int kk = 0; kk < 3; kk++)
                begin
                    t3         = 20'(u_reg[kk]) * 20'sd3;
                    v_next[kk] = VW'(t3);
                end
                state_next = ST_LD_WB;
            end
            ST_LD_WB:
            begin
                mem_we     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_R2:
            begin
                mul_a      = $signed({3'b000, radius_reg});
                mul_b      = $signed({3'b000, radius_reg});
                state_next = ST_MS2;
            end
            ST_MS2:
            begin
                r2_next    = prod_reg[45:0];
                mul_a      = $signed({3'b000, maxspd_reg});
                mul_b      = $signed({3'b000, maxspd_reg});
                state_next = ST_MS2W;
            end
            ST_MS2W:
            begin
                ms2_next   = prod_reg[45:0];
                state_next = ST_BRD;
            end
            ST_BRD:
            begin
                rd_addr    = i_reg;
                state_next = ST_BRD2;
            end
            ST_BRD2:
            begin
                for (int kk = 0; kk < 3; kk++)
                begin
                    p_next[kk]     = pos_rd_reg[kk*VW +: VW];
                    v_next[kk]     = vel_rd_reg[kk*VW +: VW];
                    sum_p_next[kk] = '0;
                    sum_u_next[kk] = '0;
                end
                j_next     = '0;
                cnt_next   = '0;
                state_next = ST_NRD;
            end
            ST_NRD:
            begin
                state_next = ST_NQ;
            end
            ST_NQ:
            begin
                for (int kk = 0; kk < 3; kk++)
                begin
                    vec_next[kk] = XW'($signed(pos_rd_reg[kk*VW +: VW])) - XW'(p_reg[kk]);
                end
                k_next      = '0;
                sq_ret_next = ST_NCMP;
                state_next  = ST_SQ;
            end
            ST_NCMP:
            begin
                if (acc_reg < {4'b0000, r2_reg})
                begin
                    for (int kk = 0; kk < 3; kk++)
                    begin
                        sum_p_next[kk] = sum_p_reg[kk]
                                       + SPW'($signed(pos_rd_reg[kk*VW +: VW]));
                        vec_next[kk]   = XW'($signed(vel_rd_reg[kk*VW +: VW]));
                    end
                    cnt_next    = cnt_reg + 7'd1;
                    k_next      = '0;
                    sq_ret_next = ST_SQRT_GO;
                    u_ret_next  = ST_NACC;
                    state_next  = ST_SQ;
                end
                else
                begin
                    state_next = ST_NNEXT;
                end
            end
            ST_NACC:
            begin
                for (int kk = 0; kk < 3; kk++)
                begin
                    sum_u_next[kk] = sum_u_reg[kk] + SUW'(u_reg[kk]);
                end
                state_next = ST_NNEXT;
            end
            ST_NNEXT:
            begin
                if ((AW+1)'(j_reg) == n_reg - 1'b1)
                begin
                    if (cnt_reg == '0)
                    begin
                        for (int kk = 0; kk < 3; kk++)
                        begin
                            avg_next[kk] = '0;
                            ali_next[kk] = '0;
                        end
                        state_next = ST_TGT;
                    end
                    else
                    begin
                        k_next     = '0;
                        state_next = ST_AVG_GO;
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_NRD;
                end
            end
            ST_AVG_GO:
            begin
                div_start  = 1'b1;
                div_num    = (k_reg < 3'd3) ? QW'(sum_p_reg[kx]) : QW'(sum_u_reg[km3[1:0]]);
                div_den    = DW'(cnt_reg);
                state_next = ST_AVG_WAIT;
            end
            ST_AVG_WAIT:
            begin
                if (div_done)
                begin
                    if (k_reg < 3'd3)
                    begin
                        avg_next[kx] = div_quot[VW-1:0];
                    end
                    else
                    begin
                        ali_next[km3[1:0]] = div_quot[UW-1:0];
                    end
                    if (k_reg == 3'd5)
                    begin
                        state_next = ST_TGT;
                    end
                    else
                    begin
                        k_next     = k_reg + 3'd1;
                        state_next = ST_AVG_GO;
                    end
                end
            end
            ST_TGT:
            begin
                for (int kk = 0; kk < 3; kk++)
                begin
                    vec_next[kk] = -XW'(p_reg[kk]);
                end
                k_next      = '0;
                sq_ret_next = ST_SQRT_GO;
                u_ret_next  = ST_VINIT;
                state_next  = ST_SQ;
            end
            ST_VINIT:
            begin
                k_next     = '0;
                term_next  = '0;
                state_next = ST_VM;
            end
            ST_VM:
            begin
                case (term_reg)
                    3'd0:
                    begin
                        mul_a = MW'(p_reg[kx]) - MW'(avg_reg[kx]);
                        mul_b = $signed({10'd0, sep_reg});
                    end
                    3'd1:
                    begin
                        mul_a = MW'(avg_reg[kx]) - MW'(p_reg[kx]);
                        mul_b = $signed({10'd0, coh_reg});
                    end
                    3'd2:
                    begin
                        mul_a = MW'(ali_reg[kx]);
                        mul_b = $signed({10'd0, aln_reg});
                    end
                    3'd3:
                    begin
                        mul_a = MW'(u_reg[kx]);
                        mul_b = $signed({10'd0, tgt_reg});
                    end
                    default:
                    begin
                        mul_a = MW'(v_reg[kx]);
                        mul_b = $signed({10'd0, dt_reg});
                    end
                endcase
                state_next = ST_VA;
            end
            ST_VA:
            begin
                if (term_reg == 3'd4)
                begin
                    p_next[kx] = sat24(38'(p_reg[kx]) + 38'(mq));
                    term_next  = '0;
                    if (kx == 2'd2)
                    begin
                        state_next = ST_SPD;
                    end
                    else
                    begin
                        k_next     = k_reg + 3'd1;
                        state_next = ST_VM;
                    end
                end
                else
                begin
                    v_next[kx] = sat24(38'(v_reg[kx]) + 38'(mq));
                    term_next  = term_reg + 3'd1;
                    state_next = ST_VM;
                end
            end
            ST_SPD:
            begin
                for (int kk = 0; kk < 3; kk++)
                begin
                    vec_next[kk] = XW'(v_reg[kk]);
                end
                k_next      = '0;
                sq_ret_next = ST_SCMP;
                state_next  = ST_SQ;
            end
            ST_SCMP:
            begin
                if (acc_reg > {4'b0000, ms2_reg})
                begin
                    u_ret_next = ST_CAPI;
                    state_next = ST_SQRT_GO;
                end
                else
                begin
                    state_next = ST_WRAP;
                end
            end
            ST_CAPI:
            begin
                k_next     = '0;
                state_next = ST_CAPM;
            end
            ST_CAPM:
            begin
                mul_a      = MW'(u_reg[kx]);
                mul_b      = $signed({3'b000, maxspd_reg});
                state_next = ST_CAPA;
            end
            ST_CAPA:
            begin
                v_next[kx] = sat24(38'(mq));
                if (kx == 2'd2)
                begin
                    state_next = ST_WRAP;
                end
                else
                begin
                    k_next     = k_reg + 3'd1;
                    state_next = ST_CAPM;
                end
            end
            ST_WRAP:
            begin
                for (int kk = 0; kk < 2; kk++)
                begin
                    pw = XW'(p_reg[kk]);
                    if (pw > bnd)
                    begin
                        pw = nbnd;
                    end
                    if (pw < nbnd)
                    begin
                        pw = bnd;
                    end
                    p_next[kk] = pw[VW-1:0];
                end
                state_next = ST_WB;
            end
            ST_WB:
            begin
                mem_we     = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (m_axis_tready)
                begin
                    if ((AW+1)'(i_reg) == n_reg - 1'b1)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_BRD;
                    end
                end
            end
            ST_SQ:
            begin
                acc_next = (k_reg == 3'd0) ? '0 : acc_reg + prod_reg[AW2-1:0];
                if (k_reg == 3'd3)
                begin
                    state_next = sq_ret_reg;
                end
                else
                begin
                    mul_a  = MW'(vec_reg[kx]);
                    mul_b  = MW'(vec_reg[kx]);
                    k_next = k_reg + 3'd1;
                end
            end
            ST_SQRT_GO:
            begin
                sqrt_start = 1'b1;
                state_next = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT:
            begin
                if (sqrt_done)
                begin
                    len_next = sqrt_root;
                    k_next   = '0;
                    if (sqrt_root == '0)
                    begin
                        for (int kk = 0; kk < 3; kk++)
                        begin
                            u_next[kk] = '0;
                        end
                        state_next = u_ret_reg;
                    end
                    else
                    begin
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                div_num    = {vec_reg[kx], 16'd0};
                div_den    = {1'b0, len_reg};
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    u_next[kx] = div_quot[UW-1:0];
                    if (kx == 2'd2)
                    begin
                        state_next = u_ret_reg;
                    end
                    else
                    begin
                        k_next     = k_reg + 3'd1;
                        state_next = ST_DIV_GO;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            sq_ret_reg <= ST_IDLE;
            u_ret_reg  <= ST_IDLE;
            k_reg      <= '0;
            term_reg   <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            n_reg      <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            sq_ret_reg <= sq_ret_next;
            u_ret_reg  <= u_ret_next;
            k_reg      <= k_next;
            term_reg   <= term_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            n_reg      <= n_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg    <= dt_next;
        p_reg     <= p_next;
        v_reg     <= v_next;
        avg_reg   <= avg_next;
        ali_reg   <= ali_next;
        u_reg     <= u_next;
        vec_reg   <= vec_next;
        sum_p_reg <= sum_p_next;
        sum_u_reg <= sum_u_next;
        acc_reg   <= acc_next;
        r2_reg    <= r2_next;
        ms2_reg   <= ms2_next;
        len_reg   <= len_next;
        prod_reg  <= mul_a * mul_b;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_EMIT);
    assign m_axis_tlast  = ((AW+1)'(i_reg) == n_reg - 1'b1);
    assign m_axis_tdata  = {2'b00, v_reg[2], v_reg[1], v_reg[0],
                            p_reg[2], p_reg[1], p_reg[0], 6'(i_reg)};

    `BFU_ASSERT_SAME(a_no_input_while_emit, m_axis_tvalid, !s_axis_tready)
    `BFU_ASSERT_NEXT(a_idle_after_last, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready)
    `BFU_ASSERT_NEXT(a_gap_after_beat, m_axis_tvalid && m_axis_tready && !m_axis_tlast, !m_axis_tvalid)
    `BFU_ASSERT_SAME(a_count_bound, state_reg != ST_IDLE, cnt_reg <= 7'(n_reg))

endmodule

>>> sim/tb_boid_flock_update.sv
// ----------------------------------------------------------------------------
// tb_boid_flock_update
// Self-checking bench for the fixed-point boids flocking step: loads and
// steps are driven as stream beats, the expected boid reports come from a
// behavioral flock model kept in a scoreboard, and configuration is changed
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_boid_flock_update;
    timeunit 1ns;
    timeprecision 1ps;

    import bfu_pkg::*;

    localparam int SLOTS       = 32;
    localparam int QUIET_LIMIT = 40000;
    localparam int SETTLE      = 400;
    localparam int HOLD_CYCLES = 3000;

    typedef struct packed {
        logic [5:0]         idx;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic signed [23:0] vz;
        logic               last;
    } boid_report_t;

    class flock_scoreboard;
        longint unsigned   cfg_val[8];
        longint            pos[SLOTS][3];
        longint            vel[SLOTS][3];
        boid_report_t      pending_reports[$];
        int                errors;

        function new();
            cfg_val = '{30, 30802, 29491, 19661, 655, 163840, 196608, 655360};
            foreach (pos[i, k])
            begin
                pos[i][k] = 0;
                vel[i][k] = 0;
            end
            errors = 0;
        endfunction

        function void set_reg(cfg_reg_t r, logic [22:0] d);
            case (r)
                REG_COUNT:                      cfg_val[int'(r)] = d[6:0];
                REG_SEP, REG_COH, REG_ALN, REG_TGT: cfg_val[int'(r)] = d[15:0];
                default:                        cfg_val[int'(r)] = d;
            endcase
        endfunction

        function longint clamp_q(longint v);
            if (v > 64'sd8388607)
            begin
                return 64'sd8388607;
            end
            if (v < -64'sd8388608)
            begin
                return -64'sd8388608;
            end
            return v;
        endfunction

        function longint scale_q(longint a, longint unsigned g);
            longint gs;
            gs = longint'(g);
            return (a * gs) / 64'sd65536;
        endfunction

        function longint unsigned root_floor(longint unsigned s);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > s)
            begin
                b = b >> 2;
            end
            while (b != 0)
            begin
                if (s >= r + b)
                begin
                    s = s - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function void unit_of(input longint v[3], output longint u[3]);
            longint unsigned s;
            longint          len;
            s = 0;
            for (int k = 0; k < 3; k++)
            begin
                s += longint'(v[k] * v[k]);
            end
            len = longint'(root_floor(s));
            for (int k = 0; k < 3; k++)
            begin
                u[k] = (len == 0) ? 0 : (v[k] * 64'sd65536) / len;
            end
        endfunction

        function void update_one(int i, int n, longint unsigned dt);
            longint          p[3], v[3], q[3], w[3], u[3], t[3];
            longint          sum_p[3], sum_u[3], avg[3], ali[3];
            longint          cnt, d;
            longint unsigned s, r2, ms2;
            r2  = cfg_val[REG_RADIUS] * cfg_val[REG_RADIUS];
            ms2 = cfg_val[REG_MAXSPD] * cfg_val[REG_MAXSPD];
            cnt = 0;
            for (int k = 0; k < 3; k++)
            begin
                p[k] = pos[i][k];
                v[k] = vel[i][k];
                sum_p[k] = 0;
                sum_u[k] = 0;
            end
            for (int j = 0; j < n; j++)
            begin
                s = 0;
                for (int k = 0; k < 3; k++)
                begin
                    q[k] = pos[j][k];
                    d = q[k] - p[k];
                    s += longint'(d * d);
                end
                if (s < r2)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        w[k] = vel[j][k];
                    end
                    unit_of(w, u);
                    for (int k = 0; k < 3; k++)
                    begin
                        sum_p[k] += q[k];
                        sum_u[k] += u[k];
                    end
                    cnt++;
                end
            end
            for (int k = 0; k < 3; k++)
            begin
                avg[k] = (cnt == 0) ? 0 : sum_p[k] / cnt;
                ali[k] = (cnt == 0) ? 0 : sum_u[k] / cnt;
                t[k]   = -p[k];
            end
            unit_of(t, u);
            for (int k = 0; k < 3; k++)
            begin
                v[k] = clamp_q(v[k] + scale_q(p[k] - avg[k], cfg_val[REG_SEP]));
                v[k] = clamp_q(v[k] + scale_q(avg[k] - p[k], cfg_val[REG_COH]));
                v[k] = clamp_q(v[k] + scale_q(ali[k], cfg_val[REG_ALN]));
                v[k] = clamp_q(v[k] + scale_q(u[k], cfg_val[REG_TGT]));
                p[k] = clamp_q(p[k] + scale_q(v[k], dt));
            end
            s = 0;
            for (int k = 0; k < 3; k++)
            begin
                s += longint'(v[k] * v[k]);
            end
            if (s > ms2)
            begin
                unit_of(v, u);
                for (int k = 0; k < 3; k++)
                begin
                    v[k] = clamp_q(scale_q(u[k], cfg_val[REG_MAXSPD]));
                end
            end
            for (int k = 0; k < 2; k++)
            begin
                if (p[k] > longint'(cfg_val[REG_BOUND]))
                begin
                    p[k] = -longint'(cfg_val[REG_BOUND]);
                end
                if (p[k] < -longint'(cfg_val[REG_BOUND]))
                begin
                    p[k] = longint'(cfg_val[REG_BOUND]);
                end
            end
            for (int k = 0; k < 3; k++)
            begin
                pos[i][k] = p[k];
                vel[i][k] = v[k];
            end
        endfunction

        function void note_input(op_t op, logic [5:0] idx, logic signed [23:0] x,
                                 logic signed [23:0] y, logic signed [23:0] z,
                                 logic [15:0] dt);
            longint       p[3], u[3];
            int           n;
            boid_report_t r;
            if (op == OP_LOAD)
            begin
                if (idx < SLOTS)
                begin
                    p[0] = x;
                    p[1] = y;
                    p[2] = z;
                    unit_of(p, u);
                    for (int k = 0; k < 3; k++)
                    begin
                        pos[idx][k] = p[k];
                        vel[idx][k] = u[k] * 3;
                    end
                end
            end
            else
            begin
                n = (cfg_val[REG_COUNT] > SLOTS) ? SLOTS : int'(cfg_val[REG_COUNT]);
                for (int i = 0; i < n; i++)
                begin
                    update_one(i, n, dt);
                    r.idx  = i[5:0];
                    r.x    = pos[i][0][23:0];
                    r.y    = pos[i][1][23:0];
                    r.z    = pos[i][2][23:0];
                    r.vx   = vel[i][0][23:0];
                    r.vy   = vel[i][1][23:0];
                    r.vz   = vel[i][2][23:0];
                    r.last = (i == n - 1);
                    pending_reports.insert(pending_reports.size(), r);
                end
            end
        endfunction

        function string report_text(boid_report_t r);
            return $sformatf("idx=%0d pos=(%0d,%0d,%0d) vel=(%0d,%0d,%0d) last=%0b",
                             r.idx, r.x, r.y, r.z, r.vx, r.vy, r.vz, r.last);
        endfunction

        function void check_result(boid_report_t got);
            boid_report_t want;
            if (pending_reports.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("unexpected beat: %s", report_text(got));
                end
                return;
            end
            want = pending_reports.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch\n  expected %s\n  actual   %s",
                             report_text(want), report_text(got));
                end
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [22:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata;
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [151:0] m_axis_tdata;
    logic         m_axis_tlast;

    flock_scoreboard sb = new();
    bit              idle_on = 1;
    bit              hold_req = 0;
    int              quiet_cycles = 0;

    boid_flock_update dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result monitor and watchdog
    always @(posedge clk)
    begin
        boid_report_t got;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.idx  = m_axis_tdata[5:0];
                got.x    = m_axis_tdata[29:6];
                got.y    = m_axis_tdata[53:30];
                got.z    = m_axis_tdata[77:54];
                got.vx   = m_axis_tdata[101:78];
                got.vy   = m_axis_tdata[125:102];
                got.vz   = m_axis_tdata[149:126];
                got.last = m_axis_tlast;
                sb.check_result(got);
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
                (cfg_valid && cfg_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[boid_flock_update] ERROR");
                $finish;
            end
        end
    end

    // result receiver
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                m_axis_tready = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
                m_axis_tready = 1'b1;
            end
            else
            begin
                m_axis_tready = 1'b1;
            end
        end
    end

    task automatic write_reg(cfg_reg_t r, logic [22:0] d);
        cfg_valid = 1'b1;
        cfg_index = r;
        cfg_data  = d;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(r, d);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_beat(op_t op, logic [5:0] idx, logic signed [23:0] x,
                             logic signed [23:0] y, logic signed [23:0] z,
                             logic [15:0] dt);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {2'b00, dt, z, y, x, idx};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_input(op, idx, x, y, z, dt);
        @(negedge clk);
    endtask

    task automatic drain_flock();
        s_axis_tvalid = 1'b0;
        while (sb.pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic signed [23:0] pick_coord(bit wide);
        logic signed [23:0] c;
        if (wide)
        begin
            c = 24'($urandom);
        end
        else
        begin
            c = 24'($urandom_range(0, 393216)) - 24'sd196608;
        end
        return c;
    endfunction

    function automatic logic [15:0] pick_gain(int mode);
        case (mode)
            0:       return 16'd0;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [22:0] pick_span(int mode, logic [22:0] dflt);
        case (mode)
            0:       return 23'd0;
            1:       return 23'h7FFFFF;
            2:       return dflt;
            3:       return 23'($urandom_range(0, 8 * 65536));
            default: return 23'($urandom);
        endcase
    endfunction

    initial
    begin
        int          mode;
        int          roll;
        bit          wide;
        logic [15:0] dt;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_LOAD;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: field extremes, zero vector, ignored slots, dt extremes
        write_reg(REG_COUNT, 23'd4);
        send_beat(OP_LOAD, 6'd0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 16'd0);
        send_beat(OP_LOAD, 6'd1, 24'sh800000, 24'sh800000, 24'sh800000, 16'hFFFF);
        send_beat(OP_LOAD, 6'd2, 24'sd0, 24'sd0, 24'sd0, 16'd0);
        send_beat(OP_LOAD, 6'd3, 24'sd65536, -24'sd65536, 24'sd32768, 16'd0);
        send_beat(OP_LOAD, 6'd32, 24'sd1, 24'sd2, 24'sd3, 16'd0);
        send_beat(OP_LOAD, 6'd63, 24'sh7FFFFF, 24'sh800000, 24'sd5, 16'hFFFF);
        send_beat(OP_STEP, 6'd0, 24'sd0, 24'sd0, 24'sd0, 16'hFFFF);
        send_beat(OP_STEP, 6'd63, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 16'd0);
        for (int i = 4; i < 8; i++)
        begin
            send_beat(OP_LOAD, 6'(i), pick_coord(0), pick_coord(0), pick_coord(0), 16'd0);
        end
        send_beat(OP_STEP, 6'd0, 24'sd0, 24'sd0, 24'sd0, 16'($urandom));
        drain_flock();

        for (int phase = 0; phase < 12; phase++)
        begin
            idle_on = (phase != 11);
            if (phase == 1)
            begin
                mode = 1;
            end
            else if (phase == 2)
            begin
                mode = 0;
            end
            else
            begin
                mode = $urandom_range(0, 5);
            end
            if (phase == 3)
            begin
                // all slots updated, count above depth, nobody in range
                write_reg(REG_COUNT, 23'd127);
                write_reg(REG_RADIUS, 23'd0);
            end
            else
            begin
                write_reg(REG_COUNT, (phase == 1 || phase == 2) ? 23'd6 :
                                     23'($urandom_range(0, 6)));
                write_reg(REG_RADIUS, pick_span(mode, 23'd163840));
            end
            write_reg(REG_SEP, pick_gain(mode));
            write_reg(REG_COH, pick_gain(mode));
            write_reg(REG_ALN, pick_gain(mode));
            write_reg(REG_TGT, pick_gain(mode));
            write_reg(REG_MAXSPD, pick_span(mode, 23'd196608));
            write_reg(REG_BOUND, pick_span(mode, 23'd655360));

            if (phase == 3)
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    wide = ($urandom_range(0, 3) == 0);
                    send_beat(OP_LOAD, 6'(i), pick_coord(wide), pick_coord(wide),
                              pick_coord(wide), 16'($urandom));
                end
                send_beat(OP_STEP, 6'($urandom), pick_coord(1), pick_coord(1),
                          pick_coord(1), 16'($urandom));
                send_beat(OP_STEP, 6'($urandom), pick_coord(1), pick_coord(1),
                          pick_coord(1), 16'hFFFF);
            end
            else
            begin
                if (phase == 5)
                begin
                    hold_req = 1;
                end
                for (int n = 0; n < 38; n++)
                begin
                    roll = $urandom_range(0, 99);
                    wide = ($urandom_range(0, 9) < 3);
                    dt   = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom);
                    if (roll < 22)
                    begin
                        send_beat(OP_STEP, 6'($urandom), pick_coord(1), pick_coord(1),
                                  pick_coord(1), dt);
                    end
                    else if (roll < 90)
                    begin
                        send_beat(OP_LOAD, 6'($urandom_range(0, 7)), pick_coord(wide),
                                  pick_coord(wide), pick_coord(wide), 16'($urandom));
                    end
                    else
                    begin
                        send_beat(OP_LOAD, 6'($urandom), pick_coord(wide),
                                  pick_coord(wide), pick_coord(wide), 16'($urandom));
                    end
                end
            end
            drain_flock();
        end

        if (sb.errors == 0 && sb.pending_reports.size() == 0)
        begin
            $display("[boid_flock_update] OK");
        end
        else
        begin
            $display("[boid_flock_update] ERROR");
        end
        $finish;
    end

endmodule

>>> boid_flock_update.f
+incdir+rtl
rtl/bfu_pkg.sv
rtl/bfu_div.sv
rtl/bfu_sqrt.sv
rtl/boid_flock_update.sv
sim/tb_boid_flock_update.sv
